### rtl/core/ktf_pkg.sv
// Shared types and constants for the Kalman trend filter with forecast.
package ktf_pkg;

    localparam int DATA_WIDTH   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_FORECAST = 63;
    localparam int DAMP_BITS    = 16;
    localparam int AHEAD_BITS   = 6;

    localparam logic [31:0] RST_Q_LEVEL   = 32'd3277;
    localparam logic [31:0] RST_Q_SLOPE   = 32'd655;
    localparam logic [31:0] RST_MEAS_NOISE = 32'd131072;
    localparam logic [31:0] RST_INIT_VAR  = 32'd65536;
    localparam logic [16:0] RST_DAMPING   = 17'd62259;
    localparam logic [5:0]  RST_FC_DAYS   = 6'd10;
    localparam logic [16:0] DAMP_ONE      = 17'd65536;

    localparam logic [2:0] REG_Q_LEVEL    = 3'd0;
    localparam logic [2:0] REG_Q_SLOPE    = 3'd1;
    localparam logic [2:0] REG_MEAS_NOISE = 3'd2;
    localparam logic [2:0] REG_INIT_VAR   = 3'd3;
    localparam logic [2:0] REG_DAMPING    = 3'd4;
    localparam logic [2:0] REG_FC_DAYS    = 3'd5;

    localparam logic [1:0] PH_EMPTY  = 2'd0;
    localparam logic [1:0] PH_SEEDED = 2'd1;
    localparam logic [1:0] PH_RUN    = 2'd2;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
        logic    damp_shift;
    } t_alu_ctl;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SLOPE,
        ST_ACC0,
        ST_ACC1,
        ST_ACC2,
        ST_P00,
        ST_P01,
        ST_P10,
        ST_P11,
        ST_PL,
        ST_ERR,
        ST_S,
        ST_K0,
        ST_K1,
        ST_ML,
        ST_MS,
        ST_MLL,
        ST_MLS,
        ST_MSL,
        ST_MSS,
        ST_OUT,
        ST_FC_LVL,
        ST_FC_MUL,
        ST_FC_OUT
    } t_state;

endpackage

### rtl/core/ktf_serial_alu.sv
// Bit-serial shift-add multiplier and restoring divider with rounding and saturation.
module ktf_serial_alu #(
    parameter int W = ktf_pkg::DATA_WIDTH,
    parameter int F = ktf_pkg::FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ktf_pkg::t_alu_ctl i_ctl,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    output logic              o_done,
    output logic [W-1:0]      o_res
);

    localparam int CW = $clog2(W + F + 1);
    localparam int PW = 2 * W + 1;
    localparam logic [PW-1:0] VMAX_P = (PW'(1) << (W - 1)) - PW'(1);
    localparam logic [PW-1:0] HALF_P = PW'(1) << (W - 1);
    localparam logic [PW-1:0] RND_F  = PW'(1) << (F - 1);
    localparam logic [PW-1:0] RND_D  = PW'(1) << (ktf_pkg::DAMP_BITS - 1);
    localparam logic [W-1:0]  VMAX   = W'((PW'(1) << (W - 1)) - PW'(1));
    localparam logic [W-1:0]  VMIN   = ~VMAX;

    logic                r_busy;
    logic                r_done;
    ktf_pkg::t_alu_op    r_op;
    logic                r_sh16;
    logic                r_neg;
    logic [CW-1:0]       r_cnt;
    logic [W:0]          r_hi;
    logic [W+F-1:0]      r_lo;
    logic [W-1:0]        r_x;
    logic [W-1:0]        r_res;

    logic [W-1:0]        mag_a;
    logic [W-1:0]        mag_b;
    logic [W:0]          mul_sum;
    logic [W:0]          div_t;
    logic                div_ge;
    logic [PW-1:0]       prod;
    logic [PW-1:0]       rnd;
    logic [PW-1:0]       m;
    logic [W-1:0]        sat_res;

    assign mag_a = i_a[W-1] ? W'(-i_a) : i_a;
    assign mag_b = i_b[W-1] ? W'(-i_b) : i_b;

    assign mul_sum = r_hi + (r_lo[0] ? {1'b0, r_x} : '0);
    assign div_t   = {r_hi[W-1:0], r_lo[W+F-1]};
    assign div_ge  = div_t >= {1'b0, r_x};

    always_comb begin
        prod = {1'b0, r_hi[W-1:0], r_lo[W-1:0]};
        rnd  = prod + (r_sh16 ? RND_D : RND_F);
        if (r_op == ktf_pkg::ALU_DIV) begin
            m = PW'(r_lo);
        end else if (r_sh16) begin
            m = rnd >> ktf_pkg::DAMP_BITS;
        end else begin
            m = rnd >> F;
        end
        if (r_neg) begin
            sat_res = (m >= HALF_P) ? VMIN : W'(-m[W-1:0]);
        end else begin
            sat_res = (m > VMAX_P) ? VMAX : m[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op   <= i_ctl.op;
            r_sh16 <= i_ctl.damp_shift;
            r_hi   <= '0;
            if (i_ctl.op == ktf_pkg::ALU_DIV) begin
                r_x   <= i_b;
                r_lo  <= {mag_a, {F{1'b0}}};
                r_cnt <= CW'(W + F);
                r_neg <= i_a[W-1];
            end else begin
                r_x   <= mag_a;
                r_lo  <= {{F{1'b0}}, mag_b};
                r_cnt <= CW'(W);
                r_neg <= i_a[W-1] ^ i_b[W-1];
            end
        end else if (r_busy && r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_op == ktf_pkg::ALU_DIV) begin
                r_hi <= div_ge ? (div_t - {1'b0, r_x}) : div_t;
                r_lo <= {r_lo[W+F-2:0], div_ge};
            end else begin
                r_hi <= mul_sum >> 1;
                r_lo <= {{F{1'b0}}, mul_sum[0], r_lo[W-1:1]};
            end
        end else if (r_busy) begin
            r_res <= sat_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

### rtl/core/kalman_trend_filter_forecast_top.sv
// Top level of the two-state Kalman trend filter with damped forecast.
//
// Input stream (i_s_*): one signed fixed-point sample per transfer, tlast marks
// the final sample of a series. Output stream (o_m_*): one filtered level per
// sample, and after a final sample forecast_days forecast levels; tuser flags a
// forecast, tlast marks the final result caused by one sample.
// Configuration through the APB port: the user writes it only while the block
// is idle; the block itself does not enforce this.
// A seeding sample's result is offered in the cycle after its transfer. A later
// sample runs ten adds (eleven for the second sample of a series), the three
// level-variance accumulations at full width and the rest saturating, and eight
// passes through the shared bit-serial unit: two gain divisions and six
// multiplies. The divisions are skipped when the innovation variance is not
// positive. Each forecast step is one saturating add and one damping multiply.
// The serial unit sets the rate: one sample is worked on at a time and the next
// is taken once its last result transfer completes. A stalled receiver holds
// the result and the sequence.
// Reset clears the filter to its unseeded state and loads register defaults.
module kalman_trend_filter_forecast_top #(
    parameter int DATA_WIDTH   = ktf_pkg::DATA_WIDTH,
    parameter int FRAC_BITS    = ktf_pkg::FRAC_BITS,
    parameter int MAX_FORECAST = ktf_pkg::MAX_FORECAST,
    parameter int IW           = ((DATA_WIDTH + 7) / 8) * 8,
    parameter int OW           = ((DATA_WIDTH + ktf_pkg::AHEAD_BITS + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [IW-1:0] i_s_tdata,   // sample
    input  logic          i_s_tlast,   // last_sample
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [OW-1:0] o_m_tdata,   // value, ahead
    output logic          o_m_tuser,   // is_forecast
    output logic          o_m_tlast,   // last
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int W  = DATA_WIDTH;
    localparam int AW = W + 3;
    localparam int AB = ktf_pkg::AHEAD_BITS;
    localparam logic [63:0]   VMAX64 = (64'd1 << (W - 1)) - 64'd1;
    localparam logic [W-1:0]  VMAX   = VMAX64[W-1:0];
    localparam logic [W-1:0]  VMIN   = ~VMAX;
    localparam logic [AW-1:0] VMAX_A = AW'(VMAX64);
    localparam logic [AW-1:0] VMIN_A = ~VMAX_A;
    localparam logic [AB-1:0] MAXF   = AB'(MAX_FORECAST);

    ktf_pkg::t_state r_state, n_state;

    logic [31:0]   r_q_level, r_q_slope, r_meas_noise, r_init_var;
    logic [16:0]   r_damping;
    logic [AB-1:0] r_fc_days;

    logic [1:0]    r_phase;
    logic          r_last;
    logic          r_issued;
    logic [AB-1:0] r_ahead;
    logic [W-1:0]  r_z, r_lvl, r_slp, r_cll, r_cls, r_csl, r_css;
    logic [W-1:0]  r_p00, r_p01, r_p10, r_p11, r_pl, r_err, r_s, r_k0, r_k1;
    logic [AW-1:0] r_acc;

    logic          cfg_wr;
    logic [2:0]    cfg_idx;
    logic          in_acc, out_acc;
    logic [W-1:0]  z_in;
    logic [W-1:0]  qlv, qsv, rnv, ivv;
    logic [W-1:0]  damp_w;
    logic [AB-1:0] days;
    logic          alu_state;
    ktf_pkg::t_alu_ctl alu_ctl;
    logic [W-1:0]  alu_a, alu_b, alu_res;
    logic          alu_done;
    logic [AW-1:0] add_a, add_b, add_sum;
    logic          add_sub;
    logic [W-1:0]  sum_sat;

    function automatic logic [W-1:0] reg_val(input logic [31:0] r);
        logic [63:0] v;
        v = {32'd0, r};
        return (v > VMAX64) ? VMAX : v[W-1:0];
    endfunction

    function automatic logic [AW-1:0] sx(input logic [W-1:0] v);
        return {{3{v[W-1]}}, v};
    endfunction

    assign qlv    = reg_val(r_q_level);
    assign qsv    = reg_val(r_q_slope);
    assign rnv    = reg_val(r_meas_noise);
    assign ivv    = reg_val(r_init_var);
    assign damp_w = W'((r_damping > ktf_pkg::DAMP_ONE) ? ktf_pkg::DAMP_ONE : r_damping);
    assign days   = (r_fc_days > MAXF) ? MAXF : r_fc_days;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_comb begin
        unique case (cfg_idx)
            ktf_pkg::REG_Q_LEVEL:    prdata = r_q_level;
            ktf_pkg::REG_Q_SLOPE:    prdata = r_q_slope;
            ktf_pkg::REG_MEAS_NOISE: prdata = r_meas_noise;
            ktf_pkg::REG_INIT_VAR:   prdata = r_init_var;
            ktf_pkg::REG_DAMPING:    prdata = {15'd0, r_damping};
            ktf_pkg::REG_FC_DAYS:    prdata = {26'd0, r_fc_days};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_level    <= ktf_pkg::RST_Q_LEVEL;
            r_q_slope    <= ktf_pkg::RST_Q_SLOPE;
            r_meas_noise <= ktf_pkg::RST_MEAS_NOISE;
            r_init_var   <= ktf_pkg::RST_INIT_VAR;
            r_damping    <= ktf_pkg::RST_DAMPING;
            r_fc_days    <= ktf_pkg::RST_FC_DAYS;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                ktf_pkg::REG_Q_LEVEL:    r_q_level    <= pwdata;
                ktf_pkg::REG_Q_SLOPE:    r_q_slope    <= pwdata;
                ktf_pkg::REG_MEAS_NOISE: r_meas_noise <= pwdata;
                ktf_pkg::REG_INIT_VAR:   r_init_var   <= pwdata;
                ktf_pkg::REG_DAMPING:    r_damping    <= pwdata[16:0];
                ktf_pkg::REG_FC_DAYS:    r_fc_days    <= pwdata[AB-1:0];
                default: ;
            endcase
        end
    end

    assign z_in    = i_s_tdata[W-1:0];
    assign in_acc  = i_s_tvalid && o_s_tready;
    assign out_acc = o_m_tvalid && i_m_tready;

    // adder operand select
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (r_state)
            ktf_pkg::ST_SLOPE:  begin add_a = sx(r_z);   add_b = sx(r_lvl); add_sub = 1'b1; end
            ktf_pkg::ST_ACC0:   begin add_a = sx(r_cll); add_b = sx(r_cls); end
            ktf_pkg::ST_ACC1:   begin add_a = r_acc;     add_b = sx(r_csl); end
            ktf_pkg::ST_ACC2:   begin add_a = r_acc;     add_b = sx(r_css); end
            ktf_pkg::ST_P00:    begin add_a = r_acc;     add_b = sx(qlv); end
            ktf_pkg::ST_P01:    begin add_a = sx(r_cls); add_b = sx(r_css); end
            ktf_pkg::ST_P10:    begin add_a = sx(r_csl); add_b = sx(r_css); end
            ktf_pkg::ST_P11:    begin add_a = sx(r_css); add_b = sx(qsv); end
            ktf_pkg::ST_PL:     begin add_a = sx(r_lvl); add_b = sx(r_slp); end
            ktf_pkg::ST_ERR:    begin add_a = sx(r_z);   add_b = sx(r_pl); add_sub = 1'b1; end
            ktf_pkg::ST_S:      begin add_a = sx(r_p00); add_b = sx(rnv); end
            ktf_pkg::ST_ML:     begin add_a = sx(r_pl);  add_b = sx(alu_res); end
            ktf_pkg::ST_MS:     begin add_a = sx(r_slp); add_b = sx(alu_res); end
            ktf_pkg::ST_MLL:    begin add_a = sx(r_p00); add_b = sx(alu_res); add_sub = 1'b1; end
            ktf_pkg::ST_MLS:    begin add_a = sx(r_p01); add_b = sx(alu_res); add_sub = 1'b1; end
            ktf_pkg::ST_MSL:    begin add_a = sx(r_p10); add_b = sx(alu_res); add_sub = 1'b1; end
            ktf_pkg::ST_MSS:    begin add_a = sx(r_p11); add_b = sx(alu_res); add_sub = 1'b1; end
            ktf_pkg::ST_FC_LVL: begin add_a = sx(r_lvl); add_b = sx(r_slp); end
            default: ;
        endcase
        add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
        if ($signed(add_sum) > $signed(VMAX_A)) begin
            sum_sat = VMAX;
        end else if ($signed(add_sum) < $signed(VMIN_A)) begin
            sum_sat = VMIN;
        end else begin
            sum_sat = add_sum[W-1:0];
        end
    end

    // serial unit operand select
    always_comb begin
        alu_state          = 1'b1;
        alu_ctl.op         = ktf_pkg::ALU_MUL;
        alu_ctl.damp_shift = 1'b0;
        alu_a              = r_k0;
        alu_b              = r_err;
        unique case (r_state)
            ktf_pkg::ST_K0:     begin alu_ctl.op = ktf_pkg::ALU_DIV; alu_a = r_p00; alu_b = r_s; end
            ktf_pkg::ST_K1:     begin alu_ctl.op = ktf_pkg::ALU_DIV; alu_a = r_p10; alu_b = r_s; end
            ktf_pkg::ST_ML:     begin alu_a = r_k0; alu_b = r_err; end
            ktf_pkg::ST_MS:     begin alu_a = r_k1; alu_b = r_err; end
            ktf_pkg::ST_MLL:    begin alu_a = r_k0; alu_b = r_p00; end
            ktf_pkg::ST_MLS:    begin alu_a = r_k0; alu_b = r_p01; end
            ktf_pkg::ST_MSL:    begin alu_a = r_k1; alu_b = r_p00; end
            ktf_pkg::ST_MSS:    begin alu_a = r_k1; alu_b = r_p01; end
            ktf_pkg::ST_FC_MUL: begin alu_a = r_slp; alu_b = damp_w; alu_ctl.damp_shift = 1'b1; end
            default:            alu_state = 1'b0;
        endcase
        alu_ctl.start = alu_state && !r_issued;
    end

    ktf_serial_alu #(
        .W (W),
        .F (FRAC_BITS)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (alu_ctl),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ktf_pkg::ST_IDLE: begin
                if (in_acc) begin
                    priority if (r_phase == ktf_pkg::PH_EMPTY)  n_state = ktf_pkg::ST_OUT;
                    else if (r_phase == ktf_pkg::PH_SEEDED)     n_state = ktf_pkg::ST_SLOPE;
                    else                                        n_state = ktf_pkg::ST_ACC0;
                end
            end
            ktf_pkg::ST_SLOPE: n_state = ktf_pkg::ST_ACC0;
            ktf_pkg::ST_ACC0:  n_state = ktf_pkg::ST_ACC1;
            ktf_pkg::ST_ACC1:  n_state = ktf_pkg::ST_ACC2;
            ktf_pkg::ST_ACC2:  n_state = ktf_pkg::ST_P00;
            ktf_pkg::ST_P00:   n_state = ktf_pkg::ST_P01;
            ktf_pkg::ST_P01:   n_state = ktf_pkg::ST_P10;
            ktf_pkg::ST_P10:   n_state = ktf_pkg::ST_P11;
            ktf_pkg::ST_P11:   n_state = ktf_pkg::ST_PL;
            ktf_pkg::ST_PL:    n_state = ktf_pkg::ST_ERR;
            ktf_pkg::ST_ERR:   n_state = ktf_pkg::ST_S;
            ktf_pkg::ST_S: begin
                n_state = ($signed(sum_sat) > 0) ? ktf_pkg::ST_K0 : ktf_pkg::ST_ML;
            end
            ktf_pkg::ST_K0:  if (alu_done) n_state = ktf_pkg::ST_K1;
            ktf_pkg::ST_K1:  if (alu_done) n_state = ktf_pkg::ST_ML;
            ktf_pkg::ST_ML:  if (alu_done) n_state = ktf_pkg::ST_MS;
            ktf_pkg::ST_MS:  if (alu_done) n_state = ktf_pkg::ST_MLL;
            ktf_pkg::ST_MLL: if (alu_done) n_state = ktf_pkg::ST_MLS;
            ktf_pkg::ST_MLS: if (alu_done) n_state = ktf_pkg::ST_MSL;
            ktf_pkg::ST_MSL: if (alu_done) n_state = ktf_pkg::ST_MSS;
            ktf_pkg::ST_MSS: if (alu_done) n_state = ktf_pkg::ST_OUT;
            ktf_pkg::ST_OUT: begin
                if (out_acc) begin
                    n_state = (r_last && days != '0) ? ktf_pkg::ST_FC_LVL : ktf_pkg::ST_IDLE;
                end
            end
            ktf_pkg::ST_FC_LVL: n_state = ktf_pkg::ST_FC_MUL;
            ktf_pkg::ST_FC_MUL: if (alu_done) n_state = ktf_pkg::ST_FC_OUT;
            ktf_pkg::ST_FC_OUT: begin
                if (out_acc) begin
                    n_state = (r_ahead == days) ? ktf_pkg::ST_IDLE : ktf_pkg::ST_FC_LVL;
                end
            end
            default: n_state = ktf_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        o_m_tuser  = 1'b0;
        o_m_tlast  = 1'b0;
        unique case (r_state)
            ktf_pkg::ST_IDLE: o_s_tready = 1'b1;
            ktf_pkg::ST_OUT: begin
                o_m_tvalid = 1'b1;
                o_m_tlast  = !r_last || days == '0;
            end
            ktf_pkg::ST_FC_OUT: begin
                o_m_tvalid = 1'b1;
                o_m_tuser  = 1'b1;
                o_m_tlast  = r_ahead == days;
            end
            default: ;
        endcase
    end

    assign o_m_tdata = OW'({(o_m_tuser ? r_ahead : AB'(0)), r_lvl});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ktf_pkg::ST_IDLE;
            r_phase  <= ktf_pkg::PH_EMPTY;
            r_issued <= 1'b0;
            r_last   <= 1'b0;
            r_ahead  <= '0;
        end else begin
            r_state <= n_state;
            if (alu_ctl.start) begin
                r_issued <= 1'b1;
            end else if (alu_done) begin
                r_issued <= 1'b0;
            end
            if (in_acc) begin
                r_last  <= i_s_tlast;
                r_ahead <= '0;
                if (r_phase == ktf_pkg::PH_EMPTY) begin
                    r_phase <= ktf_pkg::PH_SEEDED;
                end
            end
            if (r_state == ktf_pkg::ST_SLOPE) begin
                r_phase <= ktf_pkg::PH_RUN;
            end
            if (r_state == ktf_pkg::ST_FC_LVL) begin
                r_ahead <= r_ahead + AB'(1);
            end
            if (n_state == ktf_pkg::ST_IDLE && r_state != ktf_pkg::ST_IDLE && r_last) begin
                r_phase <= ktf_pkg::PH_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_z <= z_in;
            if (r_phase == ktf_pkg::PH_EMPTY) begin
                r_lvl <= z_in;
                r_slp <= '0;
                r_cll <= ivv;
                r_css <= ivv;
                r_cls <= '0;
                r_csl <= '0;
            end
        end
        unique case (r_state)
            ktf_pkg::ST_SLOPE: r_slp <= sum_sat;
            ktf_pkg::ST_ACC0,
            ktf_pkg::ST_ACC1,
            ktf_pkg::ST_ACC2:  r_acc <= add_sum;
            ktf_pkg::ST_P00:   r_p00 <= sum_sat;
            ktf_pkg::ST_P01:   r_p01 <= sum_sat;
            ktf_pkg::ST_P10:   r_p10 <= sum_sat;
            ktf_pkg::ST_P11:   r_p11 <= sum_sat;
            ktf_pkg::ST_PL:    r_pl  <= sum_sat;
            ktf_pkg::ST_ERR:   r_err <= sum_sat;
            ktf_pkg::ST_S: begin
                r_s  <= sum_sat;
                r_k0 <= '0;
                r_k1 <= '0;
            end
            ktf_pkg::ST_K0:     if (alu_done) r_k0  <= alu_res;
            ktf_pkg::ST_K1:     if (alu_done) r_k1  <= alu_res;
            ktf_pkg::ST_ML:     if (alu_done) r_lvl <= sum_sat;
            ktf_pkg::ST_MS:     if (alu_done) r_slp <= sum_sat;
            ktf_pkg::ST_MLL:    if (alu_done) r_cll <= sum_sat;
            ktf_pkg::ST_MLS:    if (alu_done) r_cls <= sum_sat;
            ktf_pkg::ST_MSL:    if (alu_done) r_csl <= sum_sat;
            ktf_pkg::ST_MSS:    if (alu_done) r_css <= sum_sat;
            ktf_pkg::ST_FC_LVL: r_lvl <= sum_sat;
            ktf_pkg::ST_FC_MUL: if (alu_done) r_slp <= alu_res;
            default: ;
        endcase
    end

endmodule

### tb/sv/tb_kalman_trend_filter_forecast_top.sv
// Testbench for kalman_trend_filter_forecast_top: streamed samples checked against a local filter.
module tb_kalman_trend_filter_forecast_top;

    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam int WDOG_LIMIT = 20000;

    typedef struct {
        logic [31:0] value;
        logic        fc;
        logic [5:0]  ahead;
        logic        last;
    } t_level_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [39:0] m_data;
    logic        m_user;
    logic        m_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    kalman_trend_filter_forecast_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tlast  (s_last),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .o_m_tuser  (m_user),
        .o_m_tlast  (m_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // filter shadow
    longint unsigned cfg_q_level, cfg_q_slope, cfg_meas_noise, cfg_init_var;
    longint unsigned cfg_damping, cfg_fc_days;
    longint          level_est, slope_est, cov_ll, cov_ls, cov_sl, cov_ss;
    logic [1:0]      filt_phase;

    t_level_out pending_levels[$];
    int         fail_count;
    int         burst_left;
    int         hold_off;
    int         rx_mode;
    int         idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint sat(longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    function automatic longint reg_level(longint unsigned r);
        return (r > longint'(VMAX)) ? VMAX : longint'(r);
    endfunction

    function automatic longint signed_clamp(logic [127:0] m, bit neg);
        longint r;
        if (m > (128'd1 << 62)) m = 128'd1 << 62;
        r = longint'(m[63:0]);
        return sat(neg ? -r : r);
    endfunction

    function automatic longint mul_round(longint a, longint b, int sh);
        logic [127:0] p;
        longint unsigned ma, mb;
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        p = 128'(ma) * 128'(mb);
        p = (p + (128'd1 << (sh - 1))) >> sh;
        return signed_clamp(p, (a < 0) != (b < 0));
    endfunction

    function automatic longint gain_div(longint num, longint den);
        logic [127:0] q;
        longint unsigned mn;
        mn = (num < 0) ? longint'(-num) : num;
        q = (128'(mn) << ktf_pkg::FRAC_BITS) / 128'(den);
        return signed_clamp(q, num < 0);
    endfunction

    function automatic void expect_level(t_level_out r);
        pending_levels.insert(pending_levels.size(), r);
    endfunction

    function automatic void clear_filter();
        level_est = 0;
        slope_est = 0;
        cov_ll = 0;
        cov_ls = 0;
        cov_sl = 0;
        cov_ss = 0;
        filt_phase = ktf_pkg::PH_EMPTY;
    endfunction

    function automatic void kalman_step(longint z);
        longint pl, ps, p00, p01, p10, p11, err, s, k0, k1;
        pl  = sat(level_est + slope_est);
        ps  = slope_est;
        p00 = sat(cov_ll + cov_ls + cov_sl + cov_ss + reg_level(cfg_q_level));
        p01 = sat(cov_ls + cov_ss);
        p10 = sat(cov_sl + cov_ss);
        p11 = sat(cov_ss + reg_level(cfg_q_slope));
        err = sat(z - pl);
        s   = sat(p00 + reg_level(cfg_meas_noise));
        k0  = 0;
        k1  = 0;
        if (s > 0) begin
            k0 = gain_div(p00, s);
            k1 = gain_div(p10, s);
        end
        level_est = sat(pl + mul_round(k0, err, ktf_pkg::FRAC_BITS));
        slope_est = sat(ps + mul_round(k1, err, ktf_pkg::FRAC_BITS));
        cov_ll = sat(p00 - mul_round(k0, p00, ktf_pkg::FRAC_BITS));
        cov_ls = sat(p01 - mul_round(k0, p01, ktf_pkg::FRAC_BITS));
        cov_sl = sat(p10 - mul_round(k1, p00, ktf_pkg::FRAC_BITS));
        cov_ss = sat(p11 - mul_round(k1, p01, ktf_pkg::FRAC_BITS));
    endfunction

    function automatic void predict_levels(logic [31:0] sample, logic fin);
        longint     z, damp;
        int         days;
        t_level_out r;
        z = longint'(signed'(sample));
        if (filt_phase == ktf_pkg::PH_EMPTY) begin
            level_est = z;
            slope_est = 0;
            cov_ll = reg_level(cfg_init_var);
            cov_ss = cov_ll;
            cov_ls = 0;
            cov_sl = 0;
            filt_phase = ktf_pkg::PH_SEEDED;
        end else begin
            if (filt_phase == ktf_pkg::PH_SEEDED) begin
                slope_est = sat(z - level_est);
                filt_phase = ktf_pkg::PH_RUN;
            end
            kalman_step(z);
        end
        days = fin ? int'(cfg_fc_days) : 0;
        if (days > ktf_pkg::MAX_FORECAST) days = ktf_pkg::MAX_FORECAST;
        r.value = level_est[31:0];
        r.fc    = 1'b0;
        r.ahead = '0;
        r.last  = (days == 0);
        expect_level(r);
        if (fin) begin
            damp = (cfg_damping > 65536) ? 65536 : longint'(cfg_damping);
            for (int i = 1; i <= days; i++) begin
                level_est = sat(level_est + slope_est);
                slope_est = mul_round(slope_est, damp, ktf_pkg::DAMP_BITS);
                r.value = level_est[31:0];
                r.fc    = 1'b1;
                r.ahead = i[5:0];
                r.last  = (i == days);
                expect_level(r);
            end
            clear_filter();
        end
    endfunction

    // receiver: random stall pattern, with a forced hold-off on request
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            m_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            if ($urandom_range(0, 63) == 0) rx_mode <= $urandom_range(0, 2);
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_level_out e;
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_levels.size() == 0) begin
                $error("unexpected result transfer value=%h", m_data[31:0]);
                fail_count++;
            end else begin
                e = pending_levels.pop_front();
                if (m_data[31:0] !== e.value) begin
                    $error("value exp=%h act=%h", e.value, m_data[31:0]);
                    fail_count++;
                end
                if (m_user !== e.fc) begin
                    $error("is_forecast exp=%b act=%b", e.fc, m_user);
                    fail_count++;
                end
                if (m_data[37:32] !== e.ahead) begin
                    $error("ahead exp=%0d act=%0d", e.ahead, m_data[37:32]);
                    fail_count++;
                end
                if (m_last !== e.last) begin
                    $error("last exp=%b act=%b", e.last, m_last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on transfer activity
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("kalman_trend_filter_forecast_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_sample(logic [31:0] sample, logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_valid <= 1'b1;
        s_data  <= sample;
        s_last  <= fin;
        do @(posedge i_clk); while (!s_ready);
        predict_levels(sample, fin);
        burst_left--;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ktf_pkg::REG_Q_LEVEL:    cfg_q_level    = val;
            ktf_pkg::REG_Q_SLOPE:    cfg_q_slope    = val;
            ktf_pkg::REG_MEAS_NOISE: cfg_meas_noise = val;
            ktf_pkg::REG_INIT_VAR:   cfg_init_var   = val;
            ktf_pkg::REG_DAMPING:    cfg_damping    = val[16:0];
            ktf_pkg::REG_FC_DAYS:    cfg_fc_days    = val[5:0];
            default: ;
        endcase
    endtask

    task automatic send_series(int len, logic [31:0] base, logic [31:0] step);
        for (int i = 0; i < len; i++)
            send_sample(base + i * step + $urandom_range(0, 4095), i == len - 1);
    endtask

    task automatic test_directed_defaults();
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b1);
        drain();
    endtask

    task automatic test_register_extremes();
        write_reg(ktf_pkg::REG_FC_DAYS, 32'd0);
        send_sample(32'h0001_0000, 1'b1);
        drain();
        write_reg(ktf_pkg::REG_FC_DAYS, 32'd63);
        write_reg(ktf_pkg::REG_DAMPING, 32'h0001_FFFF);
        send_sample(32'h0010_0000, 1'b0);
        send_sample(32'h0030_0000, 1'b1);
        drain();
        write_reg(ktf_pkg::REG_Q_LEVEL, 32'hFFFF_FFFF);
        write_reg(ktf_pkg::REG_Q_SLOPE, 32'hFFFF_FFFF);
        write_reg(ktf_pkg::REG_INIT_VAR, 32'hFFFF_FFFF);
        write_reg(ktf_pkg::REG_MEAS_NOISE, 32'd1);
        write_reg(ktf_pkg::REG_FC_DAYS, 32'd3);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h1234_5678, 1'b1);
        drain();
        write_reg(ktf_pkg::REG_Q_LEVEL, 32'd0);
        write_reg(ktf_pkg::REG_Q_SLOPE, 32'd0);
        write_reg(ktf_pkg::REG_INIT_VAR, 32'd0);
        write_reg(ktf_pkg::REG_MEAS_NOISE, 32'hFFFF_FFFF);
        write_reg(ktf_pkg::REG_DAMPING, 32'd0);
        send_sample(32'hFFFF_0000, 1'b0);
        send_sample(32'h0002_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0001, 1'b1);
        drain();
        write_reg(ktf_pkg::REG_Q_LEVEL, ktf_pkg::RST_Q_LEVEL);
        write_reg(ktf_pkg::REG_Q_SLOPE, ktf_pkg::RST_Q_SLOPE);
        write_reg(ktf_pkg::REG_MEAS_NOISE, ktf_pkg::RST_MEAS_NOISE);
        write_reg(ktf_pkg::REG_INIT_VAR, ktf_pkg::RST_INIT_VAR);
        write_reg(ktf_pkg::REG_DAMPING, 32'(ktf_pkg::DAMP_ONE));
        write_reg(ktf_pkg::REG_FC_DAYS, 32'(ktf_pkg::RST_FC_DAYS));
    endtask

    task automatic test_backpressure();
        hold_off = 900;
        send_series(6, 32'h0040_0000, 32'h0000_8000);
        drain();
    endtask

    task automatic test_random_series();
        int sent;
        int len;
        sent = 0;
        while (sent < 85) begin
            if ($urandom_range(0, 2) == 0) begin
                drain();
                write_reg(ktf_pkg::REG_Q_LEVEL,
                          $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20000));
                write_reg(ktf_pkg::REG_Q_SLOPE,
                          $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 5000));
                write_reg(ktf_pkg::REG_MEAS_NOISE,
                          $urandom_range(0, 3) == 0 ? $urandom_range(1, 32'hFFFF_FFFF)
                                                    : $urandom_range(1, 400000));
                write_reg(ktf_pkg::REG_INIT_VAR,
                          $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000));
                write_reg(ktf_pkg::REG_DAMPING, $urandom_range(0, 32'h1_FFFF));
                write_reg(ktf_pkg::REG_FC_DAYS, $urandom_range(0, 12));
            end
            len = $urandom_range(1, 12);
            if ($urandom_range(0, 4) == 0) begin
                for (int i = 0; i < len; i++) send_sample($urandom, $urandom_range(0, 7) == 0);
            end else begin
                send_series(len, $urandom, $urandom_range(0, 1) ? $urandom_range(0, 32'h4_0000)
                                                               : -$urandom_range(0, 32'h4_0000));
            end
            sent += len;
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        s_last  = 1'b0;
        m_ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        fail_count  = 0;
        burst_left  = 0;
        hold_off    = 0;
        rx_mode     = 0;
        idle_cycles = 0;
        cfg_q_level    = ktf_pkg::RST_Q_LEVEL;
        cfg_q_slope    = ktf_pkg::RST_Q_SLOPE;
        cfg_meas_noise = ktf_pkg::RST_MEAS_NOISE;
        cfg_init_var   = ktf_pkg::RST_INIT_VAR;
        cfg_damping    = ktf_pkg::RST_DAMPING;
        cfg_fc_days    = ktf_pkg::RST_FC_DAYS;
        clear_filter();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_defaults();
        test_register_extremes();
        test_backpressure();
        test_random_series();
        repeat (400) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("kalman_trend_filter_forecast_top verification clean");
        end else begin
            $display("kalman_trend_filter_forecast_top verification failed");
        end
        $finish;
    end
endmodule
